FILE: sv/cenum_pkg.sv
package cenum_pkg;

    // Field widths fixed by the interface.
    localparam int NFIELDS   = 8;
    localparam int IDX_W     = 6;
    localparam int PICK_W    = 4;
    localparam int POOL_W    = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Positions never reach the pool size, which is a 7-bit register.
    localparam int POS_W = POOL_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PICK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL = 1'b1;

    typedef enum logic [1:0] {
        MODE_ADD     = 2'd0,
        MODE_CLEAR   = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NEXT    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_COMB      = 3'd0,
        ST_FINISHED  = 3'd1,
        ST_ADDED     = 3'd2,
        ST_FULL      = 3'd3,
        ST_CLEARED   = 3'd4,
        ST_RESTARTED = 3'd5,
        ST_BADCFG    = 3'd6
    } t_status;

    // Left-to-right link between neighbouring cells.
    typedef struct packed {
        logic             chg;    // a cell further left is the pivot
        logic             match;  // every active cell so far equals the entry
        logic [POS_W-1:0] val;    // next value of the cell on the left
    } t_fwd;

endpackage

FILE: sv/cenum_cell.sv
module cenum_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_restart,
    input  logic                        i_advance,
    input  logic                        i_active,
    input  logic [cenum_pkg::POS_W-1:0] i_base,
    input  logic [cenum_pkg::IDX_W-1:0] i_ent,
    input  cenum_pkg::t_fwd             i_fwd,
    output cenum_pkg::t_fwd             o_fwd,
    input  logic                        i_rmax,
    output logic                        o_rmax,
    output logic [cenum_pkg::POS_W-1:0] o_pos
);
    import cenum_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] lim;
    logic             at_max;
    logic             pivot;

    // This cell is at its highest value when it holds n - m + IDX.
    assign lim    = i_base + POS_W'(IDX);
    assign at_max = (r_pos >= lim);
    assign pivot  = i_active && !at_max && i_rmax;
    assign o_rmax = i_rmax && (at_max || !i_active);

    always_comb begin
        if (pivot) begin
            n_pos = r_pos + POS_W'(1);
        end else if (i_fwd.chg && i_active) begin
            n_pos = i_fwd.val + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    assign o_fwd.chg   = i_fwd.chg || pivot;
    assign o_fwd.val   = n_pos;
    assign o_fwd.match = i_fwd.match && (!i_active || (r_pos == POS_W'(i_ent)));
    assign o_pos       = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pos <= POS_W'(IDX);
        end else if (i_advance) begin
            r_pos <= n_pos;
        end
    end

endmodule

FILE: sv/combination_enumerator_with_exclusions.sv
// Lexicographic m-of-n combination enumerator with an exclusion table.
//
// Requests enter on start when busy is low; i_mode selects the request and
// i_idx_0..i_idx_7 carry an exclusion entry for the add request. Every
// accepted item yields exactly one result, shown for a single cycle with
// o_valid high on o_status and o_comb_0..o_comb_7. The receiver cannot hold
// results off, so none is ever queued.
// Add, clear and restart requests, and a next request that meets a bad
// configuration or a finished walk, answer in the cycle after acceptance,
// and a new item may be taken in that same cycle.
// A next request walks the exclusion memory one entry per cycle through its
// single read port; busy stays high meanwhile.
// The positions live in a row of cells, one per index; each advance of the
// walk ripples the pivot search leftwards and the refill rightwards.
// The configuration port writes pick_count or pool_size and restarts the
// walk; the table is kept. Reset loads pick_count 2 and pool_size 4, empties
// the table, and sets the positions to 0, 1, 2 and so on. The table memory
// itself is not cleared; entries above the fill count are never read.
module combination_enumerator_with_exclusions #(
    parameter int MAX_PICK      = 8,
    parameter int MAX_POOL      = 64,
    parameter int EXCLUDE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_mode,
    input  logic [cenum_pkg::IDX_W-1:0]     i_idx_0,
    input  logic [cenum_pkg::IDX_W-1:0]     i_idx_1,
    input  logic [cenum_pkg::IDX_W-1:0]     i_idx_2,
    input  logic [cenum_pkg::IDX_W-1:0]     i_idx_3,
    input  logic [cenum_pkg::IDX_W-1:0]     i_idx_4,
    input  logic [cenum_pkg::IDX_W-1:0]     i_idx_5,
    input  logic [cenum_pkg::IDX_W-1:0]     i_idx_6,
    input  logic [cenum_pkg::IDX_W-1:0]     i_idx_7,
    input  logic                            i_cfg_we,
    input  logic [cenum_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cenum_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                            o_valid,
    output logic [2:0]                      o_status,
    output logic [cenum_pkg::IDX_W-1:0]     o_comb_0,
    output logic [cenum_pkg::IDX_W-1:0]     o_comb_1,
    output logic [cenum_pkg::IDX_W-1:0]     o_comb_2,
    output logic [cenum_pkg::IDX_W-1:0]     o_comb_3,
    output logic [cenum_pkg::IDX_W-1:0]     o_comb_4,
    output logic [cenum_pkg::IDX_W-1:0]     o_comb_5,
    output logic [cenum_pkg::IDX_W-1:0]     o_comb_6,
    output logic [cenum_pkg::IDX_W-1:0]     o_comb_7
);
    import cenum_pkg::*;

    localparam int CW    = $clog2(EXCLUDE_DEPTH + 1);
    localparam int IW    = (EXCLUDE_DEPTH > 1) ? $clog2(EXCLUDE_DEPTH) : 1;
    localparam int ENT_W = MAX_PICK * IDX_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [PICK_W-1:0]   r_pick;
    logic [POOL_W-1:0]   r_pool;
    logic [CW-1:0]       r_count, n_count;
    logic                r_done, n_done;
    logic [CW-1:0]       r_eidx, n_eidx;
    logic                r_rd_vld, n_rd_vld;
    logic [ENT_W-1:0]    r_rd_data;
    logic [ENT_W-1:0]    mem [EXCLUDE_DEPTH];
    logic                r_valid, n_valid;
    t_status             r_status, n_status;
    logic [IDX_W-1:0]    r_comb [NFIELDS];
    logic [IDX_W-1:0]    n_comb [NFIELDS];

    logic [IDX_W-1:0]    in_idx [NFIELDS];
    logic [ENT_W-1:0]    wr_ent;
    logic                accept;
    logic                cfg_ok;
    logic                room;
    logic                hit;
    logic                rd_en;
    logic                all_max;
    logic                restart;
    logic                advance;
    logic                sel_comb;
    logic [POS_W-1:0]    base;
    logic [MAX_PICK-1:0] active;
    logic [POS_W-1:0]    pos [MAX_PICK];
    t_fwd                fwd [MAX_PICK+1];
    logic [MAX_PICK:0]   rmax;

    assign in_idx[0] = i_idx_0;
    assign in_idx[1] = i_idx_1;
    assign in_idx[2] = i_idx_2;
    assign in_idx[3] = i_idx_3;
    assign in_idx[4] = i_idx_4;
    assign in_idx[5] = i_idx_5;
    assign in_idx[6] = i_idx_6;
    assign in_idx[7] = i_idx_7;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // A walk is only meaningful for 1 <= m <= MAX_PICK, 1 <= n <= MAX_POOL, m <= n.
    assign cfg_ok = (r_pick != '0) && (32'(r_pick) <= 32'(MAX_PICK)) &&
                    (r_pool != '0) && (32'(r_pool) <= 32'(MAX_POOL)) &&
                    (POOL_W'(r_pick) <= r_pool);

    assign room = (r_count < CW'(EXCLUDE_DEPTH));
    assign base = POS_W'(r_pool) - POS_W'(r_pick);

    // The row of position cells. The pivot search travels from the right,
    // the refill of the positions after the pivot travels from the left.
    assign fwd[0]         = '{chg: 1'b0, match: 1'b1, val: '0};
    assign rmax[MAX_PICK] = 1'b1;

    for (genvar k = 0; k < MAX_PICK; k++) begin : g_cell
        assign active[k] = (32'(r_pick) > k);

        // Positions beyond the input fields are stored as zero.
        if (k < NFIELDS) begin : g_wr
            assign wr_ent[k*IDX_W +: IDX_W] = in_idx[k];
        end else begin : g_wr_zero
            assign wr_ent[k*IDX_W +: IDX_W] = '0;
        end

        cenum_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_restart (restart),
            .i_advance (advance),
            .i_active  (active[k]),
            .i_base    (base),
            .i_ent     (r_rd_data[k*IDX_W +: IDX_W]),
            .i_fwd     (fwd[k]),
            .o_fwd     (fwd[k+1]),
            .i_rmax    (rmax[k+1]),
            .o_rmax    (rmax[k]),
            .o_pos     (pos[k])
        );
    end

    // No cell can step up: the current combination is the last one.
    assign all_max = rmax[0];
    assign hit     = r_rd_vld && fwd[MAX_PICK].match;
    assign rd_en   = (r_state == S_SCAN) && !hit && (r_eidx != r_count);

    // Result positions: only the first pick_count are shown, and only with
    // a combination status.
    for (genvar k = 0; k < NFIELDS; k++) begin : g_out
        if (k < MAX_PICK) begin : g_pos
            assign n_comb[k] = (sel_comb && active[k]) ? pos[k][IDX_W-1:0] : '0;
        end else begin : g_none
            assign n_comb[k] = '0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_done   = r_done;
        n_eidx   = r_eidx;
        n_rd_vld = 1'b0;
        n_valid  = 1'b0;
        n_status = r_status;
        restart  = i_cfg_we;
        advance  = 1'b0;
        sel_comb = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_mode'(i_mode))
                        MODE_ADD: begin
                            n_valid = 1'b1;
                            if (room) begin
                                n_count  = r_count + CW'(1);
                                n_status = ST_ADDED;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        MODE_CLEAR: begin
                            n_valid  = 1'b1;
                            n_count  = '0;
                            n_status = ST_CLEARED;
                        end
                        MODE_RESTART: begin
                            n_valid  = 1'b1;
                            restart  = 1'b1;
                            n_status = ST_RESTARTED;
                        end
                        MODE_NEXT: begin
                            if (!cfg_ok) begin
                                n_valid  = 1'b1;
                                n_status = ST_BADCFG;
                            end else if (r_done) begin
                                n_valid  = 1'b1;
                                n_status = ST_FINISHED;
                            end else begin
                                n_state = S_SCAN;
                                n_eidx  = '0;
                            end
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = ST_BADCFG;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    // The candidate is excluded: step on and scan again, or finish if it was the last.
                    advance = 1'b1;
                    if (all_max) begin
                        n_done   = 1'b1;
                        n_valid  = 1'b1;
                        n_status = ST_FINISHED;
                        n_state  = S_IDLE;
                    end else begin
                        n_eidx = '0;
                    end
                end else if (r_eidx == r_count) begin
                    // Every entry checked without a match: hand it out.
                    advance  = 1'b1;
                    n_done   = all_max;
                    n_valid  = 1'b1;
                    n_status = ST_COMB;
                    sel_comb = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_eidx   = r_eidx + CW'(1);
                    n_rd_vld = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pick   <= PICK_W'(2);
            r_pool   <= POOL_W'(4);
            r_count  <= '0;
            r_done   <= 1'b0;
            r_eidx   <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_done   <= restart ? 1'b0 : n_done;
            r_eidx   <= n_eidx;
            r_rd_vld <= n_rd_vld;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_PICK: r_pick <= i_cfg_data[PICK_W-1:0];
                    REG_POOL: r_pool <= i_cfg_data[POOL_W-1:0];
                    default:  r_pick <= r_pick;
                endcase
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_comb   <= n_comb;
    end

    // Exclusion memory: one write port for loading, one registered read
    // port for the scan.
    always_ff @(posedge i_clk) begin
        if (accept && (t_mode'(i_mode) == MODE_ADD) && room) begin
            mem[r_count[IW-1:0]] <= wr_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_eidx[IW-1:0]];
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_comb_0 = r_comb[0];
    assign o_comb_1 = r_comb[1];
    assign o_comb_2 = r_comb[2];
    assign o_comb_3 = r_comb[3];
    assign o_comb_4 = r_comb[4];
    assign o_comb_5 = r_comb[5];
    assign o_comb_6 = r_comb[6];
    assign o_comb_7 = r_comb[7];

    // A read of the table is only ever in flight during a scan.
    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN))
        else $error("table read outstanding outside a scan");

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(EXCLUDE_DEPTH))
        else $error("exclusion count beyond table depth");

    // The scan pointer stays within the filled part of the table.
    a_eidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_eidx <= r_count))
        else $error("scan pointer beyond fill count");

    // Leaving a scan always delivers its result in the same cycle.
    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("scan ended without a result");

    // Requests other than next answer in the following cycle.
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (t_mode'(i_mode) != MODE_NEXT)) |=> o_valid)
        else $error("missing result for a table or restart request");

endmodule
